// File: rtl/wbwl_pkg.sv
// Package: shared constants, types and state encoding for the write budget limiter.
`timescale 1ns / 1ps

package wbwl_pkg;

  // Ring geometry
  localparam int HISTORY_DEPTH = 28;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  // Field widths
  localparam int TIME_W   = 56;
  localparam int BYTES_W  = 41;
  localparam int TARGET_W = 41;
  localparam int SUM_W    = 64;
  localparam int AGE_W    = TIME_W + 1;
  localparam int LIMIT_W  = TARGET_W + 5;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);

  // Window lengths in microseconds, as signed ages
  localparam logic signed [AGE_W-1:0] DAY_US   = AGE_W'(64'd86400000000);
  localparam logic signed [AGE_W-1:0] WEEK_US  = AGE_W'(64'd604800000000);
  localparam logic signed [AGE_W-1:0] MONTH_US = AGE_W'(64'd2419200000000);

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_REC_WR,
    ST_Q_WALK,
    ST_Q_DRAIN
  } wbwl_state_e;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [SUM_W-1:0]  total;
  } wbwl_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rd_newest;
    logic rec_commit;
    logic walk_issue;
    logic out_load;
  } wbwl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_query;
    logic walk_last;
    logic pipe_busy;
    logic out_free;
  } wbwl_sts_t;

endpackage

// File: rtl/wbwl_if.sv
// Interfaces: request, response and configuration channels.
`timescale 1ns / 1ps

interface wbwl_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [wbwl_pkg::TIME_W-1:0]  event_time_us;
  logic [wbwl_pkg::BYTES_W-1:0] bytes_added;

  modport source (output valid, req_type, event_time_us, bytes_added, input ready);
  modport sink   (input valid, req_type, event_time_us, bytes_added, output ready);
endinterface

interface wbwl_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      write_allowed;
  logic [wbwl_pkg::SUM_W-1:0] sum_month;
  logic [wbwl_pkg::SUM_W-1:0] sum_week;
  logic [wbwl_pkg::SUM_W-1:0] sum_day;

  modport source (output valid, write_allowed, sum_month, sum_week, sum_day, input ready);
  modport sink   (input valid, write_allowed, sum_month, sum_week, sum_day, output ready);
endinterface

interface wbwl_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wbwl_pkg::TARGET_W-1:0] daily_write_target;

  modport source (output valid, daily_write_target, input ready);
  modport sink   (input valid, daily_write_target, output ready);
endinterface

// File: rtl/wbwl_ctrl.sv
// Controller: sequences record updates and query walks over the bucket ring.
`timescale 1ns / 1ps

module wbwl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wbwl_pkg::wbwl_sts_t sts_i,
  output wbwl_pkg::wbwl_cmd_t cmd_o
);

  wbwl_pkg::wbwl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wbwl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      wbwl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = wbwl_pkg::ST_START;
        end
      end
      wbwl_pkg::ST_START: begin
        if (sts_i.is_query) begin
          cmd_o.walk_issue = 1'b1;
          state_d = sts_i.walk_last ? wbwl_pkg::ST_Q_DRAIN : wbwl_pkg::ST_Q_WALK;
        end else begin
          cmd_o.rd_newest = 1'b1;
          state_d         = wbwl_pkg::ST_REC_WR;
        end
      end
      wbwl_pkg::ST_REC_WR: begin
        cmd_o.rec_commit = 1'b1;
        state_d          = wbwl_pkg::ST_IDLE;
      end
      wbwl_pkg::ST_Q_WALK: begin
        cmd_o.walk_issue = 1'b1;
        if (sts_i.walk_last) begin
          state_d = wbwl_pkg::ST_Q_DRAIN;
        end
      end
      wbwl_pkg::ST_Q_DRAIN: begin
        // sums are final once the read/age pipe is empty
        if (!sts_i.pipe_busy && sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = wbwl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wbwl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/wbwl_dp.sv
// Datapath: bucket memory, ring pointers, window accumulators and output register.
`timescale 1ns / 1ps

module wbwl_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wbwl_pkg::wbwl_cmd_t           cmd_i,
  output wbwl_pkg::wbwl_sts_t           sts_o,
  // request payload
  input  logic                          req_type_i,
  input  logic [wbwl_pkg::TIME_W-1:0]   event_time_us_i,
  input  logic [wbwl_pkg::BYTES_W-1:0]  bytes_added_i,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wbwl_pkg::TARGET_W-1:0] daily_write_target_i,
  // response
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output logic                          write_allowed_o,
  output logic [wbwl_pkg::SUM_W-1:0]    sum_month_o,
  output logic [wbwl_pkg::SUM_W-1:0]    sum_week_o,
  output logic [wbwl_pkg::SUM_W-1:0]    sum_day_o
);

  localparam int DEPTH = wbwl_pkg::HISTORY_DEPTH;

  // Bucket store
  wbwl_pkg::wbwl_entry_t mem_q [DEPTH];
  logic [DEPTH-1:0]      ent_vld_q;
  wbwl_pkg::wbwl_entry_t rd_ent_q;
  logic                  rd_hit_q;

  // Ring state
  logic [wbwl_pkg::SLOT_W-1:0] newest_q;
  logic [wbwl_pkg::CNT_W-1:0]  filled_q;
  logic [wbwl_pkg::SLOT_W-1:0] walk_addr_q;
  logic [wbwl_pkg::CNT_W-1:0]  rem_q;

  // Captured request
  logic                          is_query_q;
  logic [wbwl_pkg::TIME_W-1:0]   t_q;
  logic [wbwl_pkg::BYTES_W-1:0]  add_q;

  // Limits, refreshed on config writes
  logic [wbwl_pkg::LIMIT_W-1:0] lim_month_q, lim_week_q, lim_day_q;

  // Query pipe: read -> age flags -> accumulate
  logic                       a_vld_q, b_vld_q;
  logic                       b_in_month_q, b_in_week_q, b_in_day_q;
  logic [wbwl_pkg::SUM_W-1:0] b_total_q;
  logic [wbwl_pkg::SUM_W-1:0] acc_month_q, acc_week_q, acc_day_q;

  // Output register
  logic                       out_vld_q;
  logic                       out_allowed_q;
  logic [wbwl_pkg::SUM_W-1:0] out_month_q, out_week_q, out_day_q;

  logic                        rd_en;
  logic [wbwl_pkg::SLOT_W-1:0] rd_addr;
  logic                        wr_en;
  logic [wbwl_pkg::SLOT_W-1:0] wr_addr;
  wbwl_pkg::wbwl_entry_t       wr_data;
  wbwl_pkg::wbwl_entry_t       rd_view;
  logic [wbwl_pkg::SLOT_W-1:0] next_slot;
  logic [wbwl_pkg::SLOT_W-1:0] prev_walk;
  logic signed [wbwl_pkg::AGE_W-1:0] age;
  logic                        new_bucket;
  logic [wbwl_pkg::SUM_W:0]    rec_sum;
  logic [wbwl_pkg::SUM_W-1:0]  rec_total;
  logic                        out_free;
  logic                        allowed;

  function automatic logic [wbwl_pkg::SUM_W-1:0] sat_add(
    input logic [wbwl_pkg::SUM_W-1:0] a,
    input logic [wbwl_pkg::SUM_W-1:0] b
  );
    logic [wbwl_pkg::SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[wbwl_pkg::SUM_W] ? '1 : s[wbwl_pkg::SUM_W-1:0];
  endfunction

  assign rd_en     = cmd_i.rd_newest | cmd_i.walk_issue;
  assign rd_addr   = cmd_i.rd_newest ? newest_q : walk_addr_q;
  assign next_slot = (newest_q == wbwl_pkg::LAST_SLOT) ? '0 : newest_q + 1'b1;
  assign prev_walk = (walk_addr_q == '0) ? wbwl_pkg::LAST_SLOT : walk_addr_q - 1'b1;

  // never-written slots read as the empty bucket
  assign rd_view = rd_hit_q ? rd_ent_q : '0;

  assign age = $signed({1'b0, t_q}) - $signed({1'b0, rd_view.start});

  // Record: open a new bucket after a full day, else add into the newest one
  assign new_bucket = (age >= wbwl_pkg::DAY_US);
  assign rec_sum    = {1'b0, rd_view.total} +
                      {{(wbwl_pkg::SUM_W + 1 - wbwl_pkg::BYTES_W){1'b0}}, add_q};
  assign rec_total  = rec_sum[wbwl_pkg::SUM_W] ? '1 : rec_sum[wbwl_pkg::SUM_W-1:0];

  always_comb begin
    wr_en   = cmd_i.rec_commit;
    wr_addr = newest_q;
    wr_data = '{start: rd_view.start, total: rec_total};
    if (new_bucket) begin
      wr_addr = next_slot;
      wr_data = '{start: t_q,
                  total: {{(wbwl_pkg::SUM_W - wbwl_pkg::BYTES_W){1'b0}}, add_q}};
    end
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_ent_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rd_hit_q  <= 1'b0;
      newest_q  <= '0;
      filled_q  <= wbwl_pkg::CNT_W'(1);
    end else begin
      if (rd_en) begin
        rd_hit_q <= ent_vld_q[rd_addr];
      end
      if (wr_en) begin
        ent_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rec_commit && new_bucket) begin
        newest_q <= next_slot;
        if (filled_q < wbwl_pkg::FULL_CNT) begin
          filled_q <= filled_q + 1'b1;
        end
      end
    end
  end

  // Request capture and walk pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_query_q <= 1'b0;
      rem_q      <= '0;
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        is_query_q <= (req_type_i == wbwl_pkg::REQ_QUERY);
        rem_q      <= filled_q;
      end else if (cmd_i.walk_issue) begin
        rem_q <= rem_q - 1'b1;
      end
      a_vld_q <= cmd_i.walk_issue;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q         <= event_time_us_i;
      add_q       <= bytes_added_i;
      walk_addr_q <= newest_q;
    end else if (cmd_i.walk_issue) begin
      walk_addr_q <= prev_walk;
    end
    if (a_vld_q) begin
      // negative age (time went backwards) falls in every window
      b_in_month_q <= (age < wbwl_pkg::MONTH_US);
      b_in_week_q  <= (age < wbwl_pkg::WEEK_US);
      b_in_day_q   <= (age < wbwl_pkg::DAY_US);
      b_total_q    <= rd_view.total;
    end
    if (cmd_i.load) begin
      acc_month_q <= '0;
      acc_week_q  <= '0;
      acc_day_q   <= '0;
    end else if (b_vld_q) begin
      if (b_in_month_q) acc_month_q <= sat_add(acc_month_q, b_total_q);
      if (b_in_week_q)  acc_week_q  <= sat_add(acc_week_q, b_total_q);
      if (b_in_day_q)   acc_day_q   <= sat_add(acc_day_q, b_total_q);
    end
  end

  // Limits: x28, x14, x4 of the daily target
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_month_q <= '0;
      lim_week_q  <= '0;
      lim_day_q   <= '0;
    end else if (cfg_valid_i) begin
      lim_month_q <= ({5'b0, daily_write_target_i} << 5) - ({5'b0, daily_write_target_i} << 2);
      lim_week_q  <= ({5'b0, daily_write_target_i} << 4) - ({5'b0, daily_write_target_i} << 1);
      lim_day_q   <= {5'b0, daily_write_target_i} << 2;
    end
  end

  localparam int LIM_PAD = wbwl_pkg::SUM_W - wbwl_pkg::LIMIT_W;

  assign allowed = (acc_month_q < {{LIM_PAD{1'b0}}, lim_month_q}) &&
                   (acc_week_q  < {{LIM_PAD{1'b0}}, lim_week_q}) &&
                   (acc_day_q   < {{LIM_PAD{1'b0}}, lim_day_q});

  assign out_free = !out_vld_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_allowed_q <= allowed;
      out_month_q   <= acc_month_q;
      out_week_q    <= acc_week_q;
      out_day_q     <= acc_day_q;
    end
  end

  assign rsp_valid_o     = out_vld_q;
  assign write_allowed_o = out_allowed_q;
  assign sum_month_o     = out_month_q;
  assign sum_week_o      = out_week_q;
  assign sum_day_o       = out_day_q;

  assign sts_o.is_query  = is_query_q;
  assign sts_o.walk_last = (rem_q == wbwl_pkg::CNT_W'(1));
  assign sts_o.pipe_busy = a_vld_q | b_vld_q;
  assign sts_o.out_free  = out_free;

  a_filled_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (filled_q != '0) && (filled_q <= wbwl_pkg::FULL_CNT))
    else $error("filled bucket count out of range");

  a_newest_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    newest_q <= wbwl_pkg::LAST_SLOT)
    else $error("newest slot out of range");

  a_walk_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_issue |-> (rem_q != '0))
    else $error("walk issued past the filled buckets");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("response overwritten before taken");

  a_newest_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rec_commit && new_bucket) |=> ent_vld_q[newest_q])
    else $error("new bucket not marked valid");

endmodule

// File: rtl/write_budget_window_limiter.sv
// Top level: write budget limiter over a ring of daily byte buckets.
`timescale 1ns / 1ps

// Usage
//   req_i  : one request per valid/ready beat. req_type 0 records bytes_added at
//            event_time_us; req_type 1 queries the 28/7/1 day windows.
//   rsp_o  : one response per query (none per record): write_allowed and the
//            three saturated window sums.
//   cfg_i  : daily_write_target; write only while idle. Always ready.
// Timing
//   One request at a time. A record steps through accept, bucket read and
//   write back. A query walks the buckets in use (filled, 1..28) over the
//   single read port of the bucket memory, one bucket per cycle, then the
//   read and age stages. The response sits in an output register: a new
//   request is taken while it waits, and only a second query stalls at its
//   end until rsp_o drains.
// Reset
//   rst_ni is asynchronous: one zero bucket at time 0, target and limits 0,
//   no response pending. Bucket contents need no clearing pass.

module write_budget_window_limiter (
  input  logic        clk_i,
  input  logic        rst_ni,
  wbwl_req_if.sink    req_i,
  wbwl_rsp_if.source  rsp_o,
  wbwl_cfg_if.sink    cfg_i
);

  wbwl_pkg::wbwl_cmd_t cmd;
  wbwl_pkg::wbwl_sts_t sts;
  logic                in_ready;

  wbwl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wbwl_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .req_type_i           (req_i.req_type),
    .event_time_us_i      (req_i.event_time_us),
    .bytes_added_i        (req_i.bytes_added),
    .cfg_valid_i          (cfg_i.valid),
    .cfg_ready_o          (cfg_i.ready),
    .daily_write_target_i (cfg_i.daily_write_target),
    .rsp_valid_o          (rsp_o.valid),
    .rsp_ready_i          (rsp_o.ready),
    .write_allowed_o      (rsp_o.write_allowed),
    .sum_month_o          (rsp_o.sum_month),
    .sum_week_o           (rsp_o.sum_week),
    .sum_day_o            (rsp_o.sum_day)
  );

  // request side is ready only between requests
  assign req_i.ready = in_ready;

endmodule

// File: tb/sv/write_budget_window_limiter_test.sv
// Testbench: drives records and queries into the limiter and checks every query response.
`timescale 1ns / 1ps

module write_budget_window_limiter_test;

  localparam longint US_PER_DAY    = 64'd86400000000;
  localparam int     SETTLE_CYCLES = 40;    // covers the longest query walk
  localparam int     QUIET_LIMIT   = 2000;  // covers the long receiver hold-off
  localparam logic [wbwl_pkg::BYTES_W-1:0]  BYTES_MAX  = 41'd1099511627776;
  localparam logic [wbwl_pkg::TARGET_W-1:0] TARGET_MAX = 41'd1099511627776;

  typedef struct {
    logic                       allowed;
    logic [wbwl_pkg::SUM_W-1:0] month;
    logic [wbwl_pkg::SUM_W-1:0] week;
    logic [wbwl_pkg::SUM_W-1:0] day;
  } budget_answer_t;

  logic clk;
  logic rst_n;

  wbwl_req_if req_bus ();
  wbwl_rsp_if rsp_bus ();
  wbwl_cfg_if cfg_bus ();

  write_budget_window_limiter uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  // Shadow copy of the bucket ring and the target register
  logic [wbwl_pkg::TIME_W-1:0]   ring_start [wbwl_pkg::HISTORY_DEPTH];
  logic [wbwl_pkg::SUM_W-1:0]    ring_bytes [wbwl_pkg::HISTORY_DEPTH];
  int                            ring_head;
  int                            ring_used;
  logic [wbwl_pkg::TARGET_W-1:0] cur_target;

  budget_answer_t answers_due [$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_ask;
  int hold_left;
  logic [wbwl_pkg::TIME_W-1:0] sim_now;  // running clock of the well-formed traffic

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [63:0] rand_below(input logic [63:0] n);
    return {$urandom, $urandom} % n;
  endfunction

  function automatic longint age_us(input logic [wbwl_pkg::TIME_W-1:0] now,
                                    input logic [wbwl_pkg::TIME_W-1:0] start);
    return longint'({8'h00, now}) - longint'({8'h00, start});
  endfunction

  function automatic logic [wbwl_pkg::SUM_W-1:0] sat_add64(
    input logic [wbwl_pkg::SUM_W-1:0] a,
    input logic [wbwl_pkg::SUM_W-1:0] b
  );
    logic [wbwl_pkg::SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[wbwl_pkg::SUM_W] ? {wbwl_pkg::SUM_W{1'b1}} : s[wbwl_pkg::SUM_W-1:0];
  endfunction

  // Applies one accepted request to the shadow ring; a query queues its answer.
  function automatic void account_request(input logic kind,
                                          input logic [wbwl_pkg::TIME_W-1:0] t,
                                          input logic [wbwl_pkg::BYTES_W-1:0] b);
    budget_answer_t ans;
    int i;
    int k;
    longint a;
    logic [63:0] lim_month;
    logic [63:0] lim_week;
    logic [63:0] lim_day;
    if (kind == wbwl_pkg::REQ_RECORD) begin
      if (age_us(t, ring_start[ring_head]) >= US_PER_DAY) begin
        ring_head = (ring_head + 1) % wbwl_pkg::HISTORY_DEPTH;
        ring_start[ring_head] = t;
        ring_bytes[ring_head] = wbwl_pkg::SUM_W'(b);
        if (ring_used < wbwl_pkg::HISTORY_DEPTH) ring_used++;
      end else begin
        ring_bytes[ring_head] = sat_add64(ring_bytes[ring_head], wbwl_pkg::SUM_W'(b));
      end
    end else begin
      ans.month = '0;
      ans.week  = '0;
      ans.day   = '0;
      for (i = 0; i < ring_used; i++) begin
        k = (ring_head + wbwl_pkg::HISTORY_DEPTH - i) % wbwl_pkg::HISTORY_DEPTH;
        a = age_us(t, ring_start[k]);
        if (a < 28 * US_PER_DAY) ans.month = sat_add64(ans.month, ring_bytes[k]);
        if (a < 7 * US_PER_DAY)  ans.week  = sat_add64(ans.week, ring_bytes[k]);
        if (a < US_PER_DAY)      ans.day   = sat_add64(ans.day, ring_bytes[k]);
      end
      lim_month = 64'(cur_target) * 28;
      lim_week  = 64'(cur_target) * 14;
      lim_day   = 64'(cur_target) * 4;
      ans.allowed = (ans.month < lim_month) && (ans.week < lim_week) && (ans.day < lim_day);
      answers_due.push_back(ans);
    end
  endfunction

  // One request on req_bus, with random idle cycles ahead of it.
  task automatic send_request(input logic kind, input logic [wbwl_pkg::TIME_W-1:0] t,
                              input logic [wbwl_pkg::BYTES_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid         <= 1'b1;
    req_bus.req_type      <= kind;
    req_bus.event_time_us <= t;
    req_bus.bytes_added   <= b;
    do @(posedge clk); while (!req_bus.ready);
    account_request(kind, t, b);
  endtask

  // Drop valid, wait for every answer, then let in-flight records finish.
  task automatic settle();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_daily_target(input logic [wbwl_pkg::TARGET_W-1:0] value);
    settle();
    cfg_bus.valid              <= 1'b1;
    cfg_bus.daily_write_target <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cur_target = value;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Bytes scaled to the target so that the verdict flips both ways.
  function automatic logic [wbwl_pkg::BYTES_W-1:0] pick_bytes();
    logic [63:0] v;
    case ($urandom_range(9))
      0:       v = 64'd0;
      1:       v = {$urandom, $urandom} & 64'h0000_00FF_FFFF_FFFF;
      2:       v = 64'(BYTES_MAX);
      default: v = rand_below(64'(cur_target) * 4 + 1);
    endcase
    if (v > 64'(BYTES_MAX)) v = 64'(BYTES_MAX);
    return wbwl_pkg::BYTES_W'(v);
  endfunction

  task automatic test_reset_state();
    // zero target: nothing is ever allowed, sums of the empty bucket are 0
    send_request(wbwl_pkg::REQ_QUERY, '0, '0);
    send_request(wbwl_pkg::REQ_QUERY, {wbwl_pkg::TIME_W{1'b1}}, BYTES_MAX);
  endtask

  task automatic test_window_edges();
    set_daily_target(41'd100);
    send_request(wbwl_pkg::REQ_QUERY, '0, '0);
    send_request(wbwl_pkg::REQ_RECORD, wbwl_pkg::TIME_W'(5), 41'd50);
    // still slot 0
    send_request(wbwl_pkg::REQ_RECORD, wbwl_pkg::TIME_W'(US_PER_DAY - 1), BYTES_MAX);
    // opens a bucket
    send_request(wbwl_pkg::REQ_RECORD, wbwl_pkg::TIME_W'(US_PER_DAY), 41'd10);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(US_PER_DAY), '0);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(2 * US_PER_DAY - 1), '0);
    // record earlier than the newest start lands in the newest bucket
    send_request(wbwl_pkg::REQ_RECORD, wbwl_pkg::TIME_W'(US_PER_DAY / 2), 41'd7);
    // negative age
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(US_PER_DAY / 2), '0);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(7 * US_PER_DAY - 1), '0);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(7 * US_PER_DAY), '0);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(8 * US_PER_DAY), '0);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(28 * US_PER_DAY), '0);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(29 * US_PER_DAY - 1), '0);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(29 * US_PER_DAY), '0);
    send_request(wbwl_pkg::REQ_QUERY, {wbwl_pkg::TIME_W{1'b1}}, '0);
    send_request(wbwl_pkg::REQ_RECORD, wbwl_pkg::TIME_W'(3 * US_PER_DAY), 41'd1);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(3 * US_PER_DAY), '0);
    set_daily_target(TARGET_MAX);
    send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'(3 * US_PER_DAY), BYTES_MAX);
    send_request(wbwl_pkg::REQ_QUERY, {wbwl_pkg::TIME_W{1'b1}}, '0);
  endtask

  // Mostly records marching forward about a day at a time with queries in
  // between, so the ring fills and wraps; the rest is out-of-order noise.
  task automatic test_ring_traffic(input int count,
                                   input logic [wbwl_pkg::TARGET_W-1:0] target);
    int n;
    int r;
    int k;
    logic [wbwl_pkg::TIME_W-1:0] t;
    logic [63:0] step;
    set_daily_target(target);
    for (n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 60) begin
        case ($urandom_range(3))
          0:       step = rand_below(US_PER_DAY / 4);
          1:       step = US_PER_DAY - 2 + rand_below(5);  // day boundary
          2:       step = rand_below(3 * US_PER_DAY);
          default: step = US_PER_DAY + rand_below(US_PER_DAY);
        endcase
        sim_now = sim_now + wbwl_pkg::TIME_W'(step);
        send_request(wbwl_pkg::REQ_RECORD, sim_now, pick_bytes());
      end else if (r < 85) begin
        case ($urandom_range(3))
          0: t = sim_now;
          1: t = sim_now + wbwl_pkg::TIME_W'(rand_below(US_PER_DAY));
          2: begin
            // right at a window edge of some bucket in use
            k = (ring_head + wbwl_pkg::HISTORY_DEPTH - $urandom_range(ring_used - 1)) %
                wbwl_pkg::HISTORY_DEPTH;
            case ($urandom_range(2))
              0:       step = US_PER_DAY;
              1:       step = 7 * US_PER_DAY;
              default: step = 28 * US_PER_DAY;
            endcase
            t = ring_start[k] + wbwl_pkg::TIME_W'(step - 1 + rand_below(3));
          end
          default: t = sim_now + wbwl_pkg::TIME_W'(rand_below(30 * US_PER_DAY));
        endcase
        send_request(wbwl_pkg::REQ_QUERY, t, pick_bytes());
      end else if (r < 93) begin
        t = sim_now - wbwl_pkg::TIME_W'(rand_below(2 * US_PER_DAY));
        send_request(wbwl_pkg::REQ_RECORD, t, pick_bytes());
      end else begin
        send_request(wbwl_pkg::REQ_QUERY, wbwl_pkg::TIME_W'({$urandom, $urandom}),
                     pick_bytes());
      end
    end
  endtask

  // Receiver holds off while queries keep coming, so the output register
  // fills, the next query waits at its end and req_bus.ready drops.
  task automatic test_output_stall();
    int n;
    set_daily_target(wbwl_pkg::TARGET_W'({$urandom, $urandom}));
    hold_ask = 300;
    for (n = 0; n < 16; n++) begin
      if (n % 4 == 3) begin
        sim_now = sim_now + wbwl_pkg::TIME_W'(US_PER_DAY);
        send_request(wbwl_pkg::REQ_RECORD, sim_now, pick_bytes());
      end else begin
        send_request(wbwl_pkg::REQ_QUERY,
                     sim_now + wbwl_pkg::TIME_W'(rand_below(US_PER_DAY)), '0);
      end
    end
  endtask

  // Response side: random ready, long hold-off on request, field checks.
  always @(posedge clk) begin : response_check
    budget_answer_t want;
    if (rsp_bus.valid && rsp_bus.ready) begin
      if (answers_due.size() == 0) begin
        note_mismatch("response with no query waiting");
      end else begin
        want = answers_due.pop_front();
        if (rsp_bus.write_allowed !== want.allowed)
          note_mismatch($sformatf("write_allowed %b, want %b",
                                  rsp_bus.write_allowed, want.allowed));
        if (rsp_bus.sum_month !== want.month)
          note_mismatch($sformatf("sum_month %0d, want %0d", rsp_bus.sum_month, want.month));
        if (rsp_bus.sum_week !== want.week)
          note_mismatch($sformatf("sum_week %0d, want %0d", rsp_bus.sum_week, want.week));
        if (rsp_bus.sum_day !== want.day)
          note_mismatch($sformatf("sum_day %0d, want %0d", rsp_bus.sum_day, want.day));
      end
    end
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: too long without any handshake means the block is stuck.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[write_budget_window_limiter] ERROR");
    $finish;
  end

  initial begin : main_sequence
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = wbwl_pkg::REQ_RECORD;
    req_bus.event_time_us = '0;
    req_bus.bytes_added   = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.daily_write_target = '0;
    rsp_bus.ready         = 1'b0;
    error_count = 0;
    hold_ask    = 0;
    hold_left   = 0;
    // shadow state after reset: one zero bucket at time 0
    for (int i = 0; i < wbwl_pkg::HISTORY_DEPTH; i++) begin
      ring_start[i] = '0;
      ring_bytes[i] = '0;
    end
    ring_head  = 0;
    ring_used  = 1;
    cur_target = '0;
    // random start of the running clock, kept well clear of the 56-bit wrap
    sim_now = {8'($urandom_range(254)), 48'({$urandom, $urandom})};
    set_idle(37, 51);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_window_edges();
    test_ring_traffic(150, wbwl_pkg::TARGET_W'({$urandom, $urandom}));
    set_idle(51, 37);
    test_ring_traffic(150, TARGET_MAX);
    set_idle(0, 0);
    test_ring_traffic(150, 41'd1);
    test_output_stall();
    settle();

    if (error_count == 0)
      $display("[write_budget_window_limiter] OK");
    else
      $display("[write_budget_window_limiter] ERROR");
    $finish;
  end

endmodule
